// ===== hdl/sblc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblc_pkg: shared definitions for the byte-budget LRU cache
// Sizes, widths and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package sblc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;

  // Item keys arrive on a 16-bit field; only the low KEY_BITS of it count
  localparam int KEY_IN_W    = 16;
  localparam int KEY_W       = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int BYTES_W     = 32;
  localparam int TOTAL_W     = BYTES_W + 1;
  localparam int EVICT_W     = 5;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = $clog2(MAX_ENTRIES);

  localparam logic [BYTES_W-1:0] BUDGET_RESET = BYTES_W'(1048576);

  typedef struct packed {
    logic load;     // capture a new request
    logic scan;     // compare the entry at the scan index, rotate it on a match
    logic step;     // advance the scan index
    logic add;      // add the request size, or flush when it exceeds the budget
    logic evict;    // drop the least recent entry
    logic insert;   // push the request to the front
    logic publish;  // load the result register
  } sblc_cmd_t;

  typedef struct packed {
    logic matched;  // entry at the scan index holds the request key
    logic last;     // scan index is at the least recent entry
    logic empty;    // no entries held
    logic full;     // all entries held
    logic fits;     // request size is within the budget
    logic over;     // running total exceeds the budget
  } sblc_status_t;

  // Clamp an entry count to the width of the eviction counter
  function automatic logic [EVICT_W-1:0] sat_evict(input logic [CNT_W-1:0] n);
    logic [EVICT_W-1:0] r;
    if (32'(n) > 32'((1 << EVICT_W) - 1)) begin
      r = {EVICT_W{1'b1}};
    end else begin
      r = EVICT_W'(n);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/size_budget_lru_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// size_budget_lru_cache: least-recently-used key cache with a byte budget
// Tracks which item keys are cached, in recency order, under a total size cap.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on item_key / item_bytes with in_valid; a transaction
//   completes when in_valid is high and in_stall is low. Each request gives
//   one result transaction on was_hit / now_cached / evicted_count /
//   bytes_in_use under out_valid / out_stall.
//   byte_budget is written with byte_budget_wr while no request is in flight; the block does not enforce this.
//   Sequence: one request is worked at a time. A hit scans the list from
//   position 0 (the most recent) to its own position, then publishes. A
//   stored miss scans every entry held, adds the request size, evicts the
//   least recent entry one per cycle until the budget is met, inserts the
//   request and publishes; the drop forced by a full list is made in the
//   same cycle as the last budget check. An oversized miss scans every
//   entry held, flushes the list and publishes. in_stall falls in the same
//   cycle that out_valid rises, so the next request can then be accepted.
//   Stall: a finished result sits in the output register; the next request
//   is accepted and worked meanwhile, and only its final publish step holds
//   while the earlier result is still stalled.
//   Reset: the list is emptied, the byte total cleared and the budget set to
//   1048576 bytes; no clearing pass is needed.
// ----------------------------------------------------------------------------
module size_budget_lru_cache (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          byte_budget_wr,
  input  wire logic [sblc_pkg::BYTES_W-1:0]  byte_budget,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sblc_pkg::KEY_IN_W-1:0] item_key,
  input  wire logic [sblc_pkg::BYTES_W-1:0]  item_bytes,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               was_hit,
  output logic                               now_cached,
  output logic [sblc_pkg::EVICT_W-1:0]       evicted_count,
  output logic [sblc_pkg::BYTES_W-1:0]       bytes_in_use
);
  import sblc_pkg::*;

  sblc_cmd_t    cmd;
  sblc_status_t status;

  // Sequence each request: scan, account, evict, insert, publish
  sblc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the list, totals and the result register
  sblc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .byte_budget_wr (byte_budget_wr),
    .byte_budget    (byte_budget),
    .item_key       (item_key),
    .item_bytes     (item_bytes),
    .was_hit        (was_hit),
    .now_cached     (now_cached),
    .evicted_count  (evicted_count),
    .bytes_in_use   (bytes_in_use)
  );

endmodule
`default_nettype wire

// ===== hdl/sblc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblc_ctrl: request sequencer
// Steps each request through lookup and, on a miss, budget accounting, eviction
// and insertion, and owns both handshakes.
// ----------------------------------------------------------------------------
module sblc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire sblc_pkg::sblc_status_t status,
  output sblc_pkg::sblc_cmd_t        cmd
);
  import sblc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_ADD    = 6'b000100,
    ST_EVICT  = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.empty) begin
          state_next = ST_ADD;
        end else begin
          cmd.scan = 1'b1;
          if (status.matched) begin
            state_next = ST_FINISH;
          end else if (status.last) begin
            state_next = ST_ADD;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = status.fits ? ST_EVICT : ST_FINISH;
      end
      ST_EVICT: begin
        if (status.over && !status.empty) begin
          cmd.evict = 1'b1;
        end else begin
          cmd.evict  = status.full;
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sblc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblc_datapath: recency list, byte accounting and result register
// Holds the key and size of each cached entry in recency order, the entry
// count, the running byte total and the budget register.
// ----------------------------------------------------------------------------
module sblc_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sblc_pkg::sblc_cmd_t             cmd,
  output sblc_pkg::sblc_status_t               status,
  input  wire logic                            byte_budget_wr,
  input  wire logic [sblc_pkg::BYTES_W-1:0]    byte_budget,
  input  wire logic [sblc_pkg::KEY_IN_W-1:0]   item_key,
  input  wire logic [sblc_pkg::BYTES_W-1:0]    item_bytes,
  output logic                                 was_hit,
  output logic                                 now_cached,
  output logic [sblc_pkg::EVICT_W-1:0]         evicted_count,
  output logic [sblc_pkg::BYTES_W-1:0]         bytes_in_use
);
  import sblc_pkg::*;

  logic [KEY_W-1:0]   keys  [MAX_ENTRIES];
  logic [BYTES_W-1:0] sizes [MAX_ENTRIES];

  logic [CNT_W-1:0]   count;
  logic [TOTAL_W-1:0] total;
  logic [BYTES_W-1:0] budget;
  logic [IDX_W-1:0]   scan_idx;

  logic [KEY_W-1:0]   req_key;
  logic [BYTES_W-1:0] req_bytes;
  logic               hit;
  logic               held;
  logic [EVICT_W-1:0] evicted;

  logic [IDX_W-1:0]   tail_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [BYTES_W-1:0] rd_size;

  assign tail_idx = IDX_W'(count - CNT_W'(1));
  assign rd_idx   = cmd.evict ? tail_idx : scan_idx;
  assign rd_size  = sizes[rd_idx];

  always_comb begin
    status.matched = (keys[scan_idx] == req_key);
    status.last    = (scan_idx == tail_idx);
    status.empty   = (count == '0);
    status.full    = (count == CNT_W'(MAX_ENTRIES));
    status.fits    = (req_bytes <= budget);
    status.over    = (total > {1'b0, budget});
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      total    <= '0;
      budget   <= BUDGET_RESET;
      scan_idx <= '0;
    end else begin
      if (byte_budget_wr) begin
        budget <= byte_budget;
      end
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (cmd.step) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.add) begin
        if (status.fits) begin
          total <= total + {1'b0, req_bytes};
        end else begin
          total <= '0;
          count <= '0;
        end
      end else if (cmd.evict) begin
        total <= total - {1'b0, rd_size};
        count <= count - CNT_W'(1);
      end else if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Request fields and per-request flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_key   <= item_key[KEY_W-1:0];
      req_bytes <= item_bytes;
      hit       <= 1'b0;
      held      <= 1'b0;
      evicted   <= '0;
    end else begin
      if (cmd.scan && status.matched) begin
        hit  <= 1'b1;
        held <= 1'b1;
      end
      if (cmd.add && !status.fits) begin
        evicted <= sat_evict(count);
      end
      if (cmd.evict && (evicted != {EVICT_W{1'b1}})) begin
        evicted <= evicted + EVICT_W'(1);
      end
      if (cmd.insert) begin
        held <= 1'b1;
      end
    end
  end

  // Recency list: rotate a hit to the front, or push a new entry
  always_ff @(posedge clk) begin
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      if (cmd.insert || (cmd.scan && status.matched && (IDX_W'(i) <= scan_idx))) begin
        keys[i]  <= keys[i-1];
        sizes[i] <= sizes[i-1];
      end
    end
    if (cmd.insert) begin
      keys[0]  <= req_key;
      sizes[0] <= req_bytes;
    end else if (cmd.scan && status.matched) begin
      keys[0]  <= req_key;
      sizes[0] <= rd_size;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      was_hit       <= hit;
      now_cached    <= held;
      evicted_count <= evicted;
      bytes_in_use  <= total[BYTES_W-1:0];
    end
  end

endmodule
`default_nettype wire
